### hw/rtl/fqbqn_pkg.sv
package fqbqn_pkg;

  localparam logic [1:0] ENC_SANGER   = 2'd0;
  localparam logic [1:0] ENC_SOLEXA   = 2'd1;
  localparam logic [1:0] ENC_ILLUMINA = 2'd2;

  localparam logic [1:0] CFG_QUALITY_ENCODING = 2'd0;
  localparam logic [1:0] CFG_MAX_READ_LENGTH  = 2'd1;
  localparam logic [1:0] CFG_MIN_READ_LENGTH  = 2'd2;

  localparam logic [1:0]  ENCODING_RESET = ENC_SOLEXA;
  localparam logic [15:0] MAX_LEN_RESET  = 16'd2048;
  localparam logic [15:0] MIN_LEN_RESET  = 16'd64;

  localparam logic [7:0] SANGER_FLOOR = 8'd33;
  localparam logic [7:0] SOLEXA_FLOOR = 8'd64;
  localparam logic [7:0] DIGIT_ZERO   = 8'd48;
  localparam logic [7:0] BASE_N       = 8'd78;
  localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

  typedef struct packed {
    logic [7:0] base_char;
    logic [7:0] quality_char;
    logic       read_end;
  } fqbqn_in_t;

  typedef struct packed {
    logic [7:0]  base_out;
    logic [6:0]  quality_out;
    logic        kept;
    logic        quality_error;
    logic        last_out;
    logic [15:0] read_length;
    logic [15:0] error_total;
    logic        read_accepted;
  } fqbqn_out_t;

  function automatic logic [6:0] solexa_phred(input logic [4:0] x);
    logic [6:0] p;
    case (x)
      5'd0:    p = 7'd3;
      5'd1:    p = 7'd4;
      5'd2:    p = 7'd4;
      5'd3:    p = 7'd5;
      5'd4:    p = 7'd5;
      5'd5:    p = 7'd6;
      5'd6:    p = 7'd7;
      5'd7:    p = 7'd8;
      5'd8:    p = 7'd9;
      5'd9:    p = 7'd10;
      5'd10:   p = 7'd10;
      5'd11:   p = 7'd11;
      5'd12:   p = 7'd12;
      5'd13:   p = 7'd13;
      5'd14:   p = 7'd14;
      5'd15:   p = 7'd15;
      5'd16:   p = 7'd16;
      5'd17:   p = 7'd17;
      5'd18:   p = 7'd18;
      5'd19:   p = 7'd19;
      default: p = {2'b00, x};
    endcase
    return p;
  endfunction

  function automatic logic base_ok(input logic [7:0] c);
    logic ok;
    case (c)
      "A", "C", "G", "T", "N", "a", "c", "g", "t", "n": ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

### hw/rtl/fastq_base_quality_normalizer.sv
// Results are registered in out_q, via skid_q while the output is stalled.
// One item per cycle unless stalled; per-read counters update at input accept.
// A two-entry output stage (result register plus skid register) keeps the
// input open for one item while a result is stalled.
// Reset: asynchronous, active low; counters and valids clear, configuration
// returns to Solexa encoding, max length 2048, min length 64.
module fastq_base_quality_normalizer
  import fqbqn_pkg::*;
#(
  parameter int QUALITY_CEILING = 60
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  fqbqn_in_t  in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output fqbqn_out_t out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam logic [6:0] CeilingW = 7'(QUALITY_CEILING);

  logic [1:0]  encoding_q;
  logic [15:0] max_len_q, min_len_q;
  logic [15:0] pos_q, pos_d, err_cnt_q, err_cnt_d;
  logic        out_valid_q, skid_valid_q;
  fqbqn_out_t  out_q, skid_q, res;

  logic       in_acc, out_take, use_solexa_floor, err, kept;
  logic [7:0] floor_v, q_clamped, x8, qsum;
  logic [6:0] phred_raw, phred;
  logic [15:0] pos_inc, err_inc, len;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign in_acc      = in_valid_i && !skid_valid_q;
  assign out_take    = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    use_solexa_floor = (encoding_q == ENC_SOLEXA) || (encoding_q == ENC_ILLUMINA);
    floor_v   = use_solexa_floor ? SOLEXA_FLOOR : SANGER_FLOOR;
    err       = (in_data_i.quality_char < floor_v) || in_data_i.quality_char[7];
    q_clamped = err ? floor_v : in_data_i.quality_char;
    x8        = q_clamped - floor_v;
    if ((encoding_q == ENC_SOLEXA) && (x8 < 8'd20)) begin
      phred_raw = solexa_phred(x8[4:0]);
    end else begin
      phred_raw = x8[6:0];
    end
    phred = (phred_raw > CeilingW) ? CeilingW : phred_raw;
    qsum  = {1'b0, phred} + DIGIT_ZERO;

    kept    = pos_q < max_len_q;
    pos_inc = (pos_q != COUNT_MAX) ? pos_q + 16'd1 : pos_q;
    err_inc = (kept && err && (err_cnt_q != COUNT_MAX)) ? err_cnt_q + 16'd1 : err_cnt_q;
    len     = (pos_inc < max_len_q) ? pos_inc : max_len_q;

    res = '0;
    if (base_ok(in_data_i.base_char)) begin
      res.base_out    = in_data_i.base_char;
      res.quality_out = qsum[6:0];
    end else begin
      res.base_out    = BASE_N;
      res.quality_out = DIGIT_ZERO[6:0];
    end
    res.kept          = kept;
    res.quality_error = err;
    res.last_out      = in_data_i.read_end;
    if (in_data_i.read_end) begin
      res.read_length   = len;
      res.error_total   = err_inc;
      res.read_accepted = len >= min_len_q;
      pos_d     = '0;
      err_cnt_d = '0;
    end else begin
      pos_d     = pos_inc;
      err_cnt_d = err_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      encoding_q <= ENCODING_RESET;
      max_len_q  <= MAX_LEN_RESET;
      min_len_q  <= MIN_LEN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_QUALITY_ENCODING: encoding_q <= cfg_data_i[1:0];
        CFG_MAX_READ_LENGTH:  max_len_q  <= cfg_data_i;
        CFG_MIN_READ_LENGTH:  min_len_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      err_cnt_q <= '0;
    end else if (in_acc) begin
      pos_q     <= pos_d;
      err_cnt_q <= err_cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_take || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take || !out_valid_q) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_acc) begin
        out_q <= res;
      end
    end else if (in_acc) begin
      skid_q <= res;
    end
  end

endmodule

### hw/rtl/fqbqn_checker.sv
module fqbqn_checker
  import fqbqn_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input fqbqn_in_t  in_data_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input fqbqn_out_t out_data_o,
  input logic       cfg_valid_i,
  input logic       cfg_ready_o,
  input logic [1:0] cfg_index_i,
  input logic [15:0] cfg_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  a_summary_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last_out |->
      out_data_o.read_length == 16'd0 && out_data_o.error_total == 16'd0
      && !out_data_o.read_accepted)
    else $error("summary fields set on a non-last item");

  a_err_le_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last_out |->
      out_data_o.error_total <= out_data_o.read_length)
    else $error("error total exceeds kept length");

  a_base_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> base_ok(out_data_o.base_out))
    else $error("base output outside ACGTN");

endmodule

bind fastq_base_quality_normalizer fqbqn_checker u_fqbqn_checker (.*);
